[hw/rtl/systick_pkg.sv]
// Shared types and constants of the system tick timer.
package systick_pkg;

    // Default build values of the top level's parameters.
    localparam int COUNT_WIDTH_DEF  = 24;
    localparam int PRESCALE_DIV_DEF = 8;

    // Fixed field widths.
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 2;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    // Word kinds on the item channel.
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    // Timer register addresses carried by an item.
    typedef enum logic [ADDR_W-1:0] {
        ADDR_CTRL    = 2'd0,
        ADDR_RELOAD  = 2'd1,
        ADDR_CURRENT = 2'd2
    } reg_addr_t;

    // Control register bit positions.
    localparam int CTRL_ENABLE_BIT = 0;
    localparam int CTRL_IRQ_BIT    = 1;
    localparam int CTRL_CLKSRC_BIT = 2;
    localparam int CTRL_FLAG_BIT   = 16;

    // Configuration port byte address of the single-shot register.
    localparam logic [PADDR_W-1:0] PADDR_SINGLE_SHOT = 3'd0;

endpackage

[hw/rtl/systick_down_counter_timer.sv]
// Top level of the system tick timer: bus registers, down counter and result register.
//
// This block is a down-counting system tick timer. Each word on the item channel is
// either one clock tick, a read of a timer register or a write to one (kind 0, 1, 2),
// and each accepted word yields exactly one result word carrying read_data and
// irq_pulse. The timer takes one word every clock cycle while item_stall is low, and its
// result is presented in the cycle after acceptance; the counter state lives in registers
// that update at the acceptance edge, so the decrement, zero compare and reload select of
// the counter form the single path that sets that rate. A result register parts the two
// channels: a new word is taken whenever that register is empty or its word is leaving in
// the same cycle, so item_stall rises only while a result waits under result_stall.
// Control register (address 0): bit 0 enables counting, bit 1 enables the interrupt
// pulse, bit 2 selects the full-rate tick over the divided one, and bit 16 is the
// count flag, which a read of the control register returns and clears. Address 1
// holds the reload value and address 2 the current count; writing address 2 with any
// data clears the count and the flag. The single-shot register on the configuration
// port clears the enable when the count reaches zero.
module systick_down_counter_timer #(
    parameter int COUNT_WIDTH  = systick_pkg::COUNT_WIDTH_DEF,
    parameter int PRESCALE_DIV = systick_pkg::PRESCALE_DIV_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Item channel
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [systick_pkg::KIND_W-1:0]   kind,
    input  logic [systick_pkg::ADDR_W-1:0]   reg_addr,
    input  logic [systick_pkg::DATA_W-1:0]   write_data,
    // Result channel
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [systick_pkg::DATA_W-1:0]   read_data,
    output logic                             irq_pulse,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [systick_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import systick_pkg::*;

    localparam int PS_W = (PRESCALE_DIV > 1) ? $clog2(PRESCALE_DIV) : 1;
    localparam logic [PS_W-1:0] PS_LAST = PS_W'(PRESCALE_DIV - 1);

    // Timer state.
    logic [COUNT_WIDTH-1:0] count_reg,  count_next;
    logic [COUNT_WIDTH-1:0] reload_reg, reload_next;
    logic                   enable_reg, enable_next;
    logic                   irq_en_reg, irq_en_next;
    logic                   full_rate_reg, full_rate_next;
    logic                   flag_reg,   flag_next;
    logic [PS_W-1:0]        ps_reg,     ps_next;
    logic                   single_shot_reg;

    // Result register.
    logic                   result_valid_reg;
    logic [DATA_W-1:0]      read_data_reg,  read_data_next;
    logic                   irq_pulse_reg,  irq_pulse_next;

    logic                   accept;
    logic                   counted;
    logic [COUNT_WIDTH-1:0] count_dec;
    logic                   cfg_write;

    // A word is taken when the result register is free or draining this cycle.
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    assign count_dec  = count_reg - COUNT_WIDTH'(1);
    assign counted    = full_rate_reg || (ps_reg == PS_LAST);

    always_comb
    begin
        count_next     = count_reg;
        reload_next    = reload_reg;
        enable_next    = enable_reg;
        irq_en_next    = irq_en_reg;
        full_rate_next = full_rate_reg;
        flag_next      = flag_reg;
        ps_next        = ps_reg;
        read_data_next = '0;
        irq_pulse_next = 1'b0;

        if (accept)
        begin
            unique case (kind)
                KIND_TICK:
                begin
                    // A disabled timer leaves both the counter and the prescaler alone.
                    if (enable_reg)
                    begin
                        if (!full_rate_reg)
                        begin
                            ps_next = (ps_reg == PS_LAST) ? '0 : ps_reg + PS_W'(1);
                        end
                        if (counted)
                        begin
                            if (count_reg == '0)
                            begin
                                count_next = reload_reg;
                            end
                            else
                            begin
                                count_next = count_dec;
                                if (count_dec == '0)
                                begin
                                    flag_next      = 1'b1;
                                    irq_pulse_next = irq_en_reg;
                                    if (single_shot_reg)
                                    begin
                                        enable_next = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                end
                KIND_READ:
                begin
                    unique case (reg_addr)
                        ADDR_CTRL:
                        begin
                            read_data_next[CTRL_ENABLE_BIT] = enable_reg;
                            read_data_next[CTRL_IRQ_BIT]    = irq_en_reg;
                            read_data_next[CTRL_CLKSRC_BIT] = full_rate_reg;
                            read_data_next[CTRL_FLAG_BIT]   = flag_reg;
                            flag_next                       = 1'b0;
                        end
                        ADDR_RELOAD:  read_data_next = DATA_W'(reload_reg);
                        ADDR_CURRENT: read_data_next = DATA_W'(count_reg);
                        default:      read_data_next = '0;
                    endcase
                end
                KIND_WRITE:
                begin
                    unique case (reg_addr)
                        ADDR_CTRL:
                        begin
                            enable_next    = write_data[CTRL_ENABLE_BIT];
                            irq_en_next    = write_data[CTRL_IRQ_BIT];
                            full_rate_next = write_data[CTRL_CLKSRC_BIT];
                        end
                        ADDR_RELOAD:  reload_next = write_data[COUNT_WIDTH-1:0];
                        ADDR_CURRENT:
                        begin
                            count_next = '0;
                            flag_next  = 1'b0;
                        end
                        default:      count_next = count_reg;
                    endcase
                end
                default: count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            reload_reg       <= '0;
            enable_reg       <= 1'b0;
            irq_en_reg       <= 1'b0;
            full_rate_reg    <= 1'b0;
            flag_reg         <= 1'b0;
            ps_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            reload_reg    <= reload_next;
            enable_reg    <= enable_next;
            irq_en_reg    <= irq_en_next;
            full_rate_reg <= full_rate_next;
            flag_reg      <= flag_next;
            ps_reg        <= ps_next;
            if (accept)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // The result payload only loads with a new word, so it holds while stalled.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= read_data_next;
            irq_pulse_reg <= irq_pulse_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign read_data    = read_data_reg;
    assign irq_pulse    = irq_pulse_reg;

    // Configuration port: one register, written in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == PADDR_SINGLE_SHOT);
    assign prdata    = (paddr == PADDR_SINGLE_SHOT) ? {31'd0, single_shot_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_shot_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            single_shot_reg <= pwdata[0];
        end
    end

endmodule

[hw/rtl/systick_chk.sv]
// Port-level checker of the system tick timer and its bind statement.
module systick_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [31:0] read_data,
    input logic        irq_pulse
);

    // A result that is stalled stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
    else $error("result word dropped while stalled");

    // Every accepted word shows up as a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> result_valid)
    else $error("accepted word produced no result");

    // The input side only stalls behind a result that is itself stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
    else $error("input stalled without a waiting result");

    // An interrupt pulse comes only from a tick, which never carries read data.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && irq_pulse |-> read_data == 32'd0)
    else $error("interrupt pulse on a read result");

endmodule

bind systick_down_counter_timer systick_chk u_systick_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .read_data    (read_data),
    .irq_pulse    (irq_pulse)
);
